// ===== hw/rtl/glyph_template_digit_reader_defines.svh =====
// Assertion macros shared by the digit reader RTL.
`ifndef GLYPH_TEMPLATE_DIGIT_READER_DEFINES_SVH
`define GLYPH_TEMPLATE_DIGIT_READER_DEFINES_SVH

// Checks that cond implies expr in the same cycle.
`define GTDR_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Checks that cond implies expr in the following cycle.
`define GTDR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hw/rtl/gtdr_pkg.sv =====
// Types, constants and digit glyph templates of the digit reader.
`default_nettype none
package gtdr_pkg;

   localparam int GLYPH_COLUMNS  = 8;
   localparam int COLUMN_HEIGHT  = 10;
   localparam int MAX_DIGITS     = 9;
   localparam int DIGIT_CODES    = 10;
   localparam int TEMPLATE_COLS  = 8;
   localparam int TEMPLATE_IDX_W = $clog2(TEMPLATE_COLS);
   localparam int VALUE_W        = 30;
   localparam int COUNT_W        = 4;
   localparam int DIGIT_W        = 4;
   localparam int FILL_W         = $clog2(GLYPH_COLUMNS + 1);

   typedef logic [COLUMN_HEIGHT-1:0] column_type;
   typedef logic [DIGIT_CODES-1:0] hit_type;
   typedef logic [DIGIT_CODES-1:0][COLUMN_HEIGHT-1:0] glyph_slice_type;

   typedef struct packed {
      logic [9:0] column_mask;
      logic       last_column;
   } req_item_type;

   typedef struct packed {
      logic [VALUE_W-1:0] number_value;
      logic [COUNT_W-1:0] digit_count;
      logic               too_many_digits;
   } rsp_item_type;

   typedef struct packed {
      logic               match;
      logic [DIGIT_W-1:0] digit;
      logic               clear;
   } accum_ctrl_type;

   localparam column_type GLYPH_ROM [DIGIT_CODES][TEMPLATE_COLS] = '{
      '{10'h000, 10'h0F8, 10'h1FC, 10'h306, 10'h202, 10'h306, 10'h1FC, 10'h0F8},
      '{10'h000, 10'h000, 10'h204, 10'h204, 10'h3FE, 10'h3FE, 10'h200, 10'h200},
      '{10'h000, 10'h000, 10'h30C, 10'h38E, 10'h2C2, 10'h262, 10'h33E, 10'h31C},
      '{10'h000, 10'h000, 10'h18C, 10'h38E, 10'h212, 10'h212, 10'h3FE, 10'h1EC},
      '{10'h000, 10'h040, 10'h0F0, 10'h0B8, 10'h28C, 10'h3FF, 10'h3FF, 10'h280},
      '{10'h000, 10'h000, 10'h1BE, 10'h3BE, 10'h212, 10'h212, 10'h3F2, 10'h1E2},
      '{10'h000, 10'h1F8, 10'h3FC, 10'h236, 10'h212, 10'h212, 10'h3F6, 10'h1E6},
      '{10'h000, 10'h000, 10'h00E, 10'h00E, 10'h3E2, 10'h3FA, 10'h01E, 10'h006},
      '{10'h000, 10'h1CC, 10'h3FE, 10'h232, 10'h222, 10'h232, 10'h3FE, 10'h1CC},
      '{10'h000, 10'h33C, 10'h37E, 10'h242, 10'h242, 10'h362, 10'h1FE, 10'h0FC}
   };

   // Template columns past the stored glyph width are blank.
   function automatic glyph_slice_type glyph_slice(input int unsigned col);
      glyph_slice_type slice;
      for (int d = 0; d < DIGIT_CODES; d++) begin
         if (col < TEMPLATE_COLS) begin
            slice[d] = GLYPH_ROM[d][col[TEMPLATE_IDX_W-1:0]];
         end else begin
            slice[d] = '0;
         end
      end
      return slice;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gtdr_cell.sv =====
// One window column cell: holds a column and compares its next value with the templates.
`default_nettype none
module gtdr_cell
   import gtdr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            shift_en,
   input  wire column_type      col_in,
   input  wire glyph_slice_type glyph_cols,
   output column_type           col_out,
   output hit_type              hit
);

   column_type col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (shift_en) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      for (int d = 0; d < DIGIT_CODES; d++) begin
         hit[d] = (col_in == glyph_cols[d]);
      end
   end

   assign col_out = col_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/gtdr_accum.sv =====
// Decimal accumulator that appends matched digits and tracks count and overflow.
`default_nettype none
module gtdr_accum
   import gtdr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire accum_ctrl_type ctrl,
   output rsp_item_type        total
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic               room;

   assign room = (count_ff < COUNT_W'(MAX_DIGITS));

   always_comb begin
      value_in = value_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctrl.match) begin
         if (room) begin
            value_in = (value_ff << 3) + (value_ff << 1) + VALUE_W'(ctrl.digit);
            count_in = count_ff + COUNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (step) begin
         if (ctrl.clear) begin
            value_ff <= '0;
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            value_ff <= value_in;
            count_ff <= count_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   assign total.number_value    = value_in;
   assign total.digit_count     = count_in;
   assign total.too_many_digits = ovf_in;

endmodule
`default_nettype wire

// ===== hw/rtl/glyph_template_digit_reader.sv =====
// Top level of the template matching digit reader.
// The block takes one image column per cycle unless req_stall holds it. Each column shifts
// into a row of window cells that compare their incoming columns against the ten digit
// glyphs, so the template test, the digit pick and the times-ten append all finish in the
// cycle the column is accepted. The result of an image appears in the cycle after its last
// column is accepted and is held in an output register until taken; only a last column is
// stalled while a previous result still waits there.
`default_nettype none
`include "glyph_template_digit_reader_defines.svh"
module glyph_template_digit_reader
   import gtdr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   logic           accept;
   logic           last_accept;
   logic           full_next;
   logic           any_hit;
   logic           match;
   logic [FILL_W-1:0] fill_ff, fill_in, fill_next;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   total;
   accum_ctrl_type ctrl;
   hit_type        all_hit;
   logic [DIGIT_W-1:0] digit;
   column_type     window [GLYPH_COLUMNS];
   hit_type        cell_hit [GLYPH_COLUMNS];

   assign req_stall   = rsp_valid_ff && rsp_stall && req_item.last_column;
   assign accept      = req_valid && !req_stall;
   assign last_accept = accept && req_item.last_column;

   for (genvar c = 0; c < GLYPH_COLUMNS; c++) begin : g_cell
      column_type cell_in;
      if (c == GLYPH_COLUMNS - 1) begin : g_head
         assign cell_in = req_item.column_mask[COLUMN_HEIGHT-1:0];
      end else begin : g_body
         assign cell_in = window[c+1];
      end
      gtdr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .col_in     (cell_in),
         .glyph_cols (glyph_slice(c)),
         .col_out    (window[c]),
         .hit        (cell_hit[c])
      );
   end

   always_comb begin
      all_hit = '1;
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
         all_hit = all_hit & cell_hit[c];
      end
      digit = '0;
      for (int d = DIGIT_CODES - 1; d >= 0; d--) begin
         if (all_hit[d]) begin
            digit = DIGIT_W'(d);
         end
      end
   end

   assign any_hit   = |all_hit;
   assign fill_next = (fill_ff == FILL_W'(GLYPH_COLUMNS)) ? fill_ff : fill_ff + FILL_W'(1);
   assign full_next = (fill_next == FILL_W'(GLYPH_COLUMNS));
   assign match     = accept && full_next && any_hit;

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_item.last_column || match) begin
            fill_in = '0;
         end else begin
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign ctrl.match = match;
   assign ctrl.digit = digit;
   assign ctrl.clear = req_item.last_column;

   gtdr_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .ctrl  (ctrl),
      .total (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (last_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_accept) begin
         rsp_item_ff <= total;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `GTDR_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(GLYPH_COLUMNS),
      "fill count past window width")
   `GTDR_ASSERT_NEXT(a_last_emits, clock, reset, last_accept, rsp_valid_ff && fill_ff == '0,
      "last column did not emit and clear")
   `GTDR_ASSERT_NEXT(a_match_empties, clock, reset, match, fill_ff == '0,
      "match did not empty the window count")
   `GTDR_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid_ff,
      rsp_item_ff.digit_count <= COUNT_W'(MAX_DIGITS), "digit count past limit")

endmodule
`default_nettype wire
